@@ sv/patch_squared_distance_3d_top_defines.svh @@
// ----------------------------------------------------------------------------
// patch squared distance assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef PATCH_SQUARED_DISTANCE_3D_TOP_DEFINES_SVH
`define PATCH_SQUARED_DISTANCE_3D_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define PSD3_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psd3 port check failed");

// consequent checked in the cycle after the antecedent
`define PSD3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psd3 port check failed");

`endif

@@ sv/psd3_pkg.sv @@
// ----------------------------------------------------------------------------
// patch squared distance package
// field widths, register codes, defaults and shared types
// ----------------------------------------------------------------------------
package psd3_pkg;

  localparam int unsigned CFG_W      = 15;
  localparam int unsigned NTP_W      = 3;
  localparam int unsigned RAD_W      = 3;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned LOC_W      = 14;
  localparam int unsigned DIST_W     = 36;

  localparam int unsigned DEF_MAX_VOXELS       = 16384;
  localparam int unsigned DEF_MAX_TIMEPOINTS   = 4;
  localparam int unsigned DEF_MAX_PATCH_RADIUS = 4;
  localparam int unsigned DEF_SAMPLE_BITS      = 12;

  localparam logic [CFG_W-1:0] RST_X_SIZE      = CFG_W'(32);
  localparam logic [CFG_W-1:0] RST_Y_SIZE      = CFG_W'(32);
  localparam logic [CFG_W-1:0] RST_VOXEL_COUNT = CFG_W'(16384);
  localparam logic [NTP_W-1:0] RST_NUM_TP      = NTP_W'(1);
  localparam logic [RAD_W-1:0] RST_RADIUS      = RAD_W'(4);

  typedef enum logic [IDX_W-1:0] {
    REG_X_SIZE      = 3'd0,
    REG_Y_SIZE      = 3'd1,
    REG_VOXEL_COUNT = 3'd2,
    REG_NUM_TP      = 3'd3,
    REG_RADIUS      = 3'd4
  } psd3_reg_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } psd3_op_e;

  typedef struct packed {
    logic [CFG_W-1:0] x_size;
    logic [CFG_W-1:0] y_size;
    logic [CFG_W-1:0] voxel_count;
    logic [NTP_W-1:0] num_timepoints;
    logic [RAD_W-1:0] patch_radius;
  } psd3_cfg_t;

  typedef struct packed {
    logic issue;
    logic done;
  } psd3_walk_t;

endpackage

@@ sv/psd3_walk.sv @@
// ----------------------------------------------------------------------------
// patch offset walker
// steps through the cubic patch offsets and timepoints, issuing sample
// address pairs for both patch centres, at most one pair per cycle
// ----------------------------------------------------------------------------
module psd3_walk #(
  parameter int unsigned MAX_VOXELS       = psd3_pkg::DEF_MAX_VOXELS,
  parameter int unsigned MAX_TIMEPOINTS   = psd3_pkg::DEF_MAX_TIMEPOINTS,
  parameter int unsigned MAX_PATCH_RADIUS = psd3_pkg::DEF_MAX_PATCH_RADIUS,
  localparam int unsigned AW = $clog2(MAX_VOXELS * MAX_TIMEPOINTS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [psd3_pkg::LOC_W-1:0]   loc_a_i,
  input  logic [psd3_pkg::LOC_W-1:0]   loc_b_i,
  input  psd3_pkg::psd3_cfg_t          cfg_i,
  output psd3_pkg::psd3_walk_t         ctl_o,
  output logic [AW-1:0]                addr_a_o,
  output logic [AW-1:0]                addr_b_o
);

  localparam int unsigned CW    = psd3_pkg::CFG_W;
  localparam int unsigned RW    = $clog2(MAX_PATCH_RADIUS + 1);
  localparam int unsigned CNT_W = RW + 1;
  localparam int unsigned TP_W  = $clog2(MAX_TIMEPOINTS + 1);
  localparam int unsigned NV_W  = $clog2(MAX_VOXELS + 1);
  localparam int unsigned OFF_W = 2 * CW + RW + 2;

  typedef enum logic [2:0] {
    W_IDLE,
    W_XY,
    W_RX,
    W_INIT,
    W_WALK
  } walk_state_e;

  walk_state_e state_q;

  logic [psd3_pkg::LOC_W-1:0] la_q, lb_q;
  logic [2*CW-1:0]            xy_q;
  logic [CW+RW-1:0]           rx_q;
  logic [2*CW+RW-1:0]         rxy_q;
  logic signed [OFF_W-1:0]    s_q, row_q, slice_q;
  logic [CNT_W-1:0]           cx_q, cy_q, cz_q;
  logic [TP_W-1:0]            tp_q;
  logic [AW-1:0]              pa_q, pb_q;

  logic [RW-1:0]           r;
  logic [CNT_W-1:0]        r2;
  logic [TP_W-1:0]         ntp;
  logic [NV_W-1:0]         nv;
  logic signed [OFF_W:0]   ia_a, ia_b;
  logic                    in_a, in_b, first, pair_ok, last_tp, step, last_off;
  logic signed [OFF_W-1:0] s_init, row_next, slice_next;

  always_comb begin
    r = (32'(cfg_i.patch_radius) > MAX_PATCH_RADIUS) ? RW'(MAX_PATCH_RADIUS)
                                                       : RW'(cfg_i.patch_radius);
    r2  = CNT_W'(r) + CNT_W'(r);
    ntp = (32'(cfg_i.num_timepoints) > MAX_TIMEPOINTS) ? TP_W'(MAX_TIMEPOINTS)
                                                         : TP_W'(cfg_i.num_timepoints);
    nv  = (32'(cfg_i.voxel_count) > MAX_VOXELS) ? NV_W'(MAX_VOXELS)
                                                  : NV_W'(cfg_i.voxel_count);

    ia_a = (OFF_W+1)'(signed'({1'b0, la_q})) + (OFF_W+1)'(s_q);
    ia_b = (OFF_W+1)'(signed'({1'b0, lb_q})) + (OFF_W+1)'(s_q);
    in_a = !ia_a[OFF_W] && (ia_a[OFF_W-1:0] < OFF_W'(nv));
    in_b = !ia_b[OFF_W] && (ia_b[OFF_W-1:0] < OFF_W'(nv));

    first    = (tp_q == '0);
    pair_ok  = in_a && in_b && (ntp != '0);
    last_tp  = (TP_W'(tp_q + 1'b1) == ntp);
    step     = (state_q == W_WALK) && ((first && !pair_ok) || last_tp);
    last_off = (cx_q == r2) && (cy_q == r2) && (cz_q == r2);

    s_init     = OFF_W'(0) - OFF_W'(r) - OFF_W'(rx_q) - OFF_W'(rxy_q);
    row_next   = row_q + OFF_W'(cfg_i.x_size);
    slice_next = slice_q + OFF_W'(xy_q);

    ctl_o.issue = (state_q == W_WALK) && (first ? pair_ok : 1'b1);
    ctl_o.done  = step && last_off;
    addr_a_o    = first ? ia_a[AW-1:0] : pa_q;
    addr_b_o    = first ? ia_b[AW-1:0] : pb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      cx_q    <= '0;
      cy_q    <= '0;
      cz_q    <= '0;
      tp_q    <= '0;
    end else begin
      unique case (state_q)
        W_IDLE: begin
          if (start_i) begin
            state_q <= W_XY;
          end
        end
        W_XY: begin
          state_q <= W_RX;
        end
        W_RX: begin
          state_q <= W_INIT;
        end
        W_INIT: begin
          state_q <= W_WALK;
          cx_q    <= '0;
          cy_q    <= '0;
          cz_q    <= '0;
          tp_q    <= '0;
        end
        W_WALK: begin
          if (step) begin
            tp_q <= '0;
            if (last_off) begin
              state_q <= W_IDLE;
            end else if (cx_q != r2) begin
              cx_q <= cx_q + 1'b1;
            end else if (cy_q != r2) begin
              cx_q <= '0;
              cy_q <= cy_q + 1'b1;
            end else begin
              cx_q <= '0;
              cy_q <= '0;
              cz_q <= cz_q + 1'b1;
            end
          end else begin
            tp_q <= tp_q + 1'b1;
          end
        end
        default: begin
          state_q <= W_IDLE;
        end
      endcase
    end
  end

  // offsets and addresses
  always_ff @(posedge clk_i) begin
    if (state_q == W_IDLE && start_i) begin
      la_q <= loc_a_i;
      lb_q <= loc_b_i;
    end
    if (state_q == W_XY) begin
      xy_q <= (2*CW)'(cfg_i.x_size) * (2*CW)'(cfg_i.y_size);
    end
    if (state_q == W_RX) begin
      rx_q  <= (CW+RW)'(r) * (CW+RW)'(cfg_i.x_size);
      rxy_q <= (2*CW+RW)'(r) * (2*CW+RW)'(xy_q);
    end
    if (state_q == W_INIT) begin
      s_q     <= s_init;
      row_q   <= s_init;
      slice_q <= s_init;
    end
    if (state_q == W_WALK) begin
      if (first) begin
        pa_q <= ia_a[AW-1:0] + AW'(nv);
        pb_q <= ia_b[AW-1:0] + AW'(nv);
      end else begin
        pa_q <= pa_q + AW'(nv);
        pb_q <= pb_q + AW'(nv);
      end
      if (step && !last_off) begin
        if (cx_q != r2) begin
          s_q <= s_q + OFF_W'(1);
        end else if (cy_q != r2) begin
          row_q <= row_next;
          s_q   <= row_next;
        end else begin
          slice_q <= slice_next;
          row_q   <= slice_next;
          s_q     <= slice_next;
        end
      end
    end
  end

endmodule

@@ sv/patch_squared_distance_3d_top.sv @@
// ----------------------------------------------------------------------------
// patch squared distance 3d, top level
// Sample store for a multi-timepoint volume with a patch distance engine.
// A write item stores one sample. A query runs the setup states W_XY, W_RX
// and W_INIT, then walks the offsets of the (2R+1)^3 patch, skipping an
// offset whose pair leaves the volume and reading every timepoint of an
// offset whose pair is inside, then drains the read, square and accumulate
// stages. The query time is set by the single sample memory, which serves
// one address pair per cycle on its two read ports. The next item is taken
// once the result sits in the output register.
// The store needs no clearing pass; entries never written read as garbage.
// ----------------------------------------------------------------------------
module patch_squared_distance_3d_top #(
  parameter int unsigned MAX_VOXELS       = psd3_pkg::DEF_MAX_VOXELS,
  parameter int unsigned MAX_TIMEPOINTS   = psd3_pkg::DEF_MAX_TIMEPOINTS,
  parameter int unsigned MAX_PATCH_RADIUS = psd3_pkg::DEF_MAX_PATCH_RADIUS,
  parameter int unsigned SAMPLE_BITS      = psd3_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [psd3_pkg::ADDR_W-1:0]   write_address_i,
  input  logic [psd3_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [psd3_pkg::LOC_W-1:0]    location_a_i,
  input  logic [psd3_pkg::LOC_W-1:0]    location_b_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [psd3_pkg::DIST_W-1:0]   distance_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [psd3_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [psd3_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int unsigned STORE_DEPTH = MAX_VOXELS * MAX_TIMEPOINTS;
  localparam int unsigned AW     = $clog2(STORE_DEPTH);
  localparam int unsigned WA_W   = psd3_pkg::ADDR_W + AW;
  localparam int unsigned SX_W   = SAMPLE_BITS + psd3_pkg::SAMPLE_W;
  localparam int unsigned ACC_W  = 2 * SAMPLE_BITS +
      $clog2(MAX_TIMEPOINTS * (2 * MAX_PATCH_RADIUS + 1) ** 3 + 1);
  localparam int unsigned DW     = psd3_pkg::DIST_W;
  localparam int unsigned SAT_W  = (ACC_W > DW) ? ACC_W : DW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_e;

  state_e state_q;
  logic          out_valid_q;
  logic [DW-1:0] distance_q;

  psd3_pkg::psd3_cfg_t  cfg_q;
  psd3_pkg::psd3_walk_t walk;

  logic [SAMPLE_BITS-1:0] mem_q [STORE_DEPTH];
  logic [AW-1:0]          addr_a, addr_b;
  logic [SAMPLE_BITS-1:0] rd_a_q, rd_b_q;
  logic                   vld1_q, vld2_q;
  logic [2*SAMPLE_BITS-1:0] sq_q;
  logic [ACC_W-1:0]       acc_q;

  logic                           in_xfer, query, wr_ok, drained, out_free;
  logic [WA_W-1:0]                waddr_ext;
  logic [SX_W-1:0]                sample_ext;
  logic signed [SAMPLE_BITS:0]    diff;
  logic [2*SAMPLE_BITS+1:0]       sq_full;
  logic [SAT_W-1:0]               acc_ext;
  logic [DW-1:0]                  dist_sat;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign distance_o  = distance_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    in_xfer    = in_valid_i && !in_stall_o;
    query      = in_xfer && (op_i == psd3_pkg::OP_QUERY);
    waddr_ext  = WA_W'(write_address_i);
    wr_ok      = in_xfer && (op_i == psd3_pkg::OP_WRITE) &&
                 (waddr_ext < WA_W'(STORE_DEPTH));
    sample_ext = SX_W'(sample_i);
    diff       = signed'({1'b0, rd_a_q}) - signed'({1'b0, rd_b_q});
    sq_full    = unsigned'((2*SAMPLE_BITS+2)'(diff) * (2*SAMPLE_BITS+2)'(diff));
    acc_ext    = SAT_W'(acc_q);
    dist_sat   = (acc_ext > SAT_W'({DW{1'b1}})) ? {DW{1'b1}} : acc_ext[DW-1:0];
    drained    = !vld1_q && !vld2_q;
    out_free   = !out_valid_q || !out_stall_i;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_size         <= psd3_pkg::RST_X_SIZE;
      cfg_q.y_size         <= psd3_pkg::RST_Y_SIZE;
      cfg_q.voxel_count    <= psd3_pkg::RST_VOXEL_COUNT;
      cfg_q.num_timepoints <= psd3_pkg::RST_NUM_TP;
      cfg_q.patch_radius   <= psd3_pkg::RST_RADIUS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        psd3_pkg::REG_X_SIZE:      cfg_q.x_size         <= cfg_data_i;
        psd3_pkg::REG_Y_SIZE:      cfg_q.y_size         <= cfg_data_i;
        psd3_pkg::REG_VOXEL_COUNT: cfg_q.voxel_count    <= cfg_data_i;
        psd3_pkg::REG_NUM_TP:      cfg_q.num_timepoints <= cfg_data_i[psd3_pkg::NTP_W-1:0];
        psd3_pkg::REG_RADIUS:      cfg_q.patch_radius   <= cfg_data_i[psd3_pkg::RAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  psd3_walk #(
    .MAX_VOXELS      (MAX_VOXELS),
    .MAX_TIMEPOINTS  (MAX_TIMEPOINTS),
    .MAX_PATCH_RADIUS(MAX_PATCH_RADIUS)
  ) u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (query),
    .loc_a_i (location_a_i),
    .loc_b_i (location_b_i),
    .cfg_i   (cfg_q),
    .ctl_o   (walk),
    .addr_a_o(addr_a),
    .addr_b_o(addr_b)
  );

  // sample store
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[waddr_ext[AW-1:0]] <= sample_ext[SAMPLE_BITS-1:0];
    end
    if (walk.issue) begin
      rd_a_q <= mem_q[addr_a];
      rd_b_q <= mem_q[addr_b];
    end
  end

  // square and accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= walk.issue;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld1_q) begin
      sq_q <= sq_full[2*SAMPLE_BITS-1:0];
    end
    if (query) begin
      acc_q <= '0;
    end else if (vld2_q) begin
      acc_q <= acc_q + ACC_W'(sq_q);
    end
  end

  // control and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      distance_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (query) begin
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (walk.done) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drained && out_free) begin
            out_valid_q <= 1'b1;
            distance_q  <= dist_sat;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/psd3_checker.sv @@
// ----------------------------------------------------------------------------
// patch squared distance port checker
// port level checks on transfer ordering, bound to the top level
// ----------------------------------------------------------------------------
`include "patch_squared_distance_3d_top_defines.svh"

module psd3_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          op_i,
  input logic [psd3_pkg::ADDR_W-1:0]   write_address_i,
  input logic [psd3_pkg::SAMPLE_W-1:0] sample_i,
  input logic [psd3_pkg::LOC_W-1:0]    location_a_i,
  input logic [psd3_pkg::LOC_W-1:0]    location_b_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [psd3_pkg::DIST_W-1:0]   distance_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [psd3_pkg::IDX_W-1:0]    cfg_index_i,
  input logic [psd3_pkg::CFG_W-1:0]    cfg_data_i
);

  // stalled result keeps its value
  `PSD3_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(distance_o))

  // an accepted query blocks further input transfers
  `PSD3_ASSERT_NEXT(a_query_busy, in_valid_i && !in_stall_o && op_i == psd3_pkg::OP_QUERY, in_stall_o)

  // no result appears right after an input transfer
  `PSD3_ASSERT_NEXT(a_no_early_result, in_valid_i && !in_stall_o, !$rose(out_valid_o))

  // a new result reopens the input
  `PSD3_ASSERT_NOW(a_result_frees_input, $rose(out_valid_o), !in_stall_o)

endmodule

bind patch_squared_distance_3d_top psd3_checker u_psd3_checker (.*);
